FILE: rtl/hcv_pkg.sv
// shared types and constants for the harris corner vote window
// no dependencies
package hcv_pkg;

    localparam int unsigned CfgWidth = 12;
    localparam int unsigned VoteWidth = 30;
    localparam int unsigned CoordWidth = 11;

    // configuration register indexes
    localparam logic CFG_WIDTH = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // front to back queue entry
    typedef struct packed {
        logic [15:0]           cur;
        logic [15:0]           up1;
        logic [15:0]           up2;
        logic                  emit;
        logic [CoordWidth-1:0] col;
        logic [CoordWidth-1:0] row;
    } t_pix;

endpackage

FILE: rtl/hcv_ram.sv
// generic simple dual port ram with registered read
// no dependencies
module hcv_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // registered read, returns the old word when the write hits the same address
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/hcv_front.sv
// front: position counters, line stores, classification of each item
// depends on hcv_pkg and hcv_ram
module hcv_front #(
    parameter int unsigned MAX_WIDTH = 2048,
    parameter int unsigned MAX_HEIGHT = 2048
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [7:0]                     i_grad_x,
    input  logic [7:0]                     i_grad_y,
    input  logic [hcv_pkg::CfgWidth-1:0]   i_width,
    input  logic [hcv_pkg::CfgWidth-1:0]   i_height,
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output hcv_pkg::t_pix                  o_q_data
);
    import hcv_pkg::*;

    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned CW = $clog2(MAX_WIDTH + 1) + 1;
    localparam int unsigned RW = $clog2(MAX_HEIGHT + 1) + 1;

    logic [CW-1:0] r_col, n_col, w_eff;
    logic [RW-1:0] r_row, n_row, h_eff;
    logic          acc;
    logic          r_v;
    logic          r_inram;
    logic          r_emit;
    logic [15:0]   r_cur;
    logic [CW-1:0] r_pcol;
    logic [RW-1:0] r_prow;
    logic [15:0]   up1, up2, up2_q, cur;
    logic          inram, emit;
    logic          r_bpend;
    logic          r_bfwd;
    logic [15:0]   r_bfwd_data;

    // stage register is free when empty or draining into the queue
    assign o_full = r_v && i_q_full;
    assign acc    = i_push && !o_full;
    assign cur    = {i_grad_y, i_grad_x};

    // effective geometry
    always_comb begin
        if (CW'(i_width) > CW'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(i_width);
        end
        if (RW'(i_height) > RW'(MAX_HEIGHT)) begin
            h_eff = RW'(MAX_HEIGHT);
        end else begin
            h_eff = RW'(i_height);
        end
    end

    assign inram = r_col < CW'(MAX_WIDTH);
    assign emit  = (r_col >= CW'(3)) && (r_col + CW'(2) <= w_eff)
                && (r_row >= RW'(3)) && (r_row + RW'(1) <= h_eff);

    // counter advance with wrap at row end and at frame end
    always_comb begin
        n_col = r_col + CW'(1);
        n_row = r_row;
        if (r_col + CW'(1) >= w_eff) begin
            n_col = '0;
            n_row = (r_row + RW'(1) >= h_eff) ? '0 : r_row + RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_v     <= 1'b0;
            r_bpend <= 1'b0;
            r_bfwd  <= 1'b0;
        end else begin
            if (acc) begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_bpend <= inram;
                r_bfwd  <= r_bpend && inram && (r_pcol[AW-1:0] == r_col[AW-1:0]);
            end
            if (acc) begin
                r_v <= 1'b1;
            end else if (!i_q_full) begin
                r_v <= 1'b0;
            end
        end
    end

    // payload of the stage
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_cur       <= cur;
            r_inram     <= inram;
            r_emit      <= emit;
            r_pcol      <= r_col;
            r_prow      <= r_row;
            r_bfwd_data <= up1;
        end
    end

    // line stores: a holds the previous row, b the row before
    hcv_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_line_a (
        .i_clk   (i_clk),
        .i_re    (acc && inram),
        .i_raddr (r_col[AW-1:0]),
        .o_rdata (up1),
        .i_we    (acc && inram),
        .i_waddr (r_col[AW-1:0]),
        .i_wdata (cur)
    );

    // b takes the old word of a for the previous item, written with the next item
    hcv_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_line_b (
        .i_clk   (i_clk),
        .i_re    (acc && inram),
        .i_raddr (r_col[AW-1:0]),
        .o_rdata (up2),
        .i_we    (acc && r_bpend),
        .i_waddr (r_pcol[AW-1:0]),
        .i_wdata (up1)
    );

    // back to back items on one column: the b word is still on its way in
    assign up2_q = r_bfwd ? r_bfwd_data : up2;

    assign o_q_push      = r_v && !i_q_full;
    assign o_q_data.cur  = r_cur;
    assign o_q_data.up1  = r_inram ? up1 : 16'h0;
    assign o_q_data.up2  = r_inram ? up2_q : 16'h0;
    assign o_q_data.emit = r_emit;
    assign o_q_data.col  = CoordWidth'(r_pcol - CW'(1));
    assign o_q_data.row  = CoordWidth'(r_prow - RW'(1));
endmodule

FILE: rtl/hcv_fifo.sv
// short queue between front and back
// depends on hcv_pkg
module hcv_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hcv_pkg::t_pix i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output hcv_pkg::t_pix o_data
);
    import hcv_pkg::*;

    localparam int unsigned PW = $clog2(DEPTH);

    t_pix            r_mem [DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;

    assign o_full  = r_cnt == (PW+1)'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

FILE: rtl/hcv_back.sv
// back: 3x3 window, sums and vote pipeline with output queue
// depends on hcv_pkg
module hcv_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_empty,
    output logic                             o_q_pop,
    input  hcv_pkg::t_pix                    i_q_data,
    output logic                             o_empty,
    input  logic                             i_pop,
    output logic [hcv_pkg::VoteWidth-1:0]    o_vote,
    output logic [hcv_pkg::CoordWidth-1:0]   o_col,
    output logic [hcv_pkg::CoordWidth-1:0]   o_row
);
    import hcv_pkg::*;

    localparam int unsigned OD = 8;        // output queue depth
    localparam int unsigned OW = $clog2(OD);

    typedef struct packed {
        logic [VoteWidth-1:0]  vote;
        logic [CoordWidth-1:0] col;
        logic [CoordWidth-1:0] row;
    } t_res;

    logic [15:0] r_win [9];
    logic        adv;
    logic [OW:0] r_ocnt;
    logic [2:0]  r_inflight;

    // window advances only when the output queue has room for every vote in flight
    assign adv     = !i_q_empty && ((r_ocnt + (OW+1)'(r_inflight)) < (OW+1)'(OD));
    assign o_q_pop = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (adv) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]   <= r_win[r*3+1];
                r_win[r*3+1] <= r_win[r*3+2];
            end
            r_win[2] <= i_q_data.up2;
            r_win[5] <= i_q_data.up1;
            r_win[8] <= i_q_data.cur;
        end
    end

    // stage 1: products of the new window
    logic               r1_v;
    logic [CoordWidth-1:0] r1_col, r1_row;
    logic [15:0] win_n [9];
    logic [14:0] r1_xx [9];
    logic [14:0] r1_yy [9];
    logic signed [15:0] r1_xy [9];
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            win_n[r*3]   = r_win[r*3+1];
            win_n[r*3+1] = r_win[r*3+2];
        end
        win_n[2] = i_q_data.up2;
        win_n[5] = i_q_data.up1;
        win_n[8] = i_q_data.cur;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 9; k++) begin
                r1_xx[k] <= 15'($signed(win_n[k][7:0]) * $signed(win_n[k][7:0]));
                r1_yy[k] <= 15'($signed(win_n[k][15:8]) * $signed(win_n[k][15:8]));
                r1_xy[k] <= $signed(win_n[k][7:0]) * $signed(win_n[k][15:8]);
            end
            r1_col <= i_q_data.col;
            r1_row <= i_q_data.row;
        end
    end

    // stage 2: window sums
    logic        r2_v;
    logic [CoordWidth-1:0] r2_col, r2_row;
    logic [18:0] r2_xx, r2_yy;
    logic signed [19:0] r2_xy;
    always_ff @(posedge i_clk) begin
        logic [18:0] sx, sy;
        logic signed [19:0] sxy;
        sx = '0;
        sy = '0;
        sxy = '0;
        for (int k = 0; k < 9; k++) begin
            sx  = sx + 19'(r1_xx[k]);
            sy  = sy + 19'(r1_yy[k]);
            sxy = sxy + 20'(r1_xy[k]);
        end
        r2_xx  <= sx;
        r2_yy  <= sy;
        r2_xy  <= sxy;
        r2_col <= r1_col;
        r2_row <= r1_row;
    end

    // stage 3: scaled terms and products
    logic        r3_v;
    logic [CoordWidth-1:0] r3_col, r3_row;
    logic [31:0] r3_det1, r3_xy2, r3_tr2;
    always_ff @(posedge i_clk) begin
        logic signed [19:0] q;
        logic [16:0] tr;
        q  = (r2_xy < 0) ? -((-r2_xy) >>> 3) : (r2_xy >>> 3);
        tr = 17'((20'(r2_xx) + 20'(r2_yy)) >> 3);
        r3_det1 <= 32'({16'h0, r2_xx[18:3]} * {16'h0, r2_yy[18:3]});
        r3_xy2  <= 32'($signed(q[16:0]) * $signed(q[16:0]));
        r3_tr2  <= 32'({15'h0, tr} * {15'h0, tr});
        r3_col  <= r2_col;
        r3_row  <= r2_row;
    end

    // stage 4: combine
    logic        r4_v;
    logic [CoordWidth-1:0] r4_col, r4_row;
    logic signed [35:0] r4_vote;
    always_ff @(posedge i_clk) begin
        logic [35:0] t3;
        t3 = (36'(r3_tr2) * 36'd3) >> 6;
        r4_vote <= $signed(36'(r3_det1)) - $signed(36'(r3_xy2)) - $signed(t3);
        r4_col  <= r3_col;
        r4_row  <= r3_row;
    end

    // valid chain for emitted votes only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            r1_v <= adv && i_q_data.emit;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end
    assign r_inflight = 3'(r1_v) + 3'(r2_v) + 3'(r3_v) + 3'(r4_v);

    // output queue
    t_res          r_omem [OD];
    logic [OW-1:0] r_owp, r_orp;
    logic          opop;
    assign o_empty = r_ocnt == '0;
    assign opop    = i_pop && !o_empty;
    assign o_vote  = r_omem[r_orp].vote;
    assign o_col   = r_omem[r_orp].col;
    assign o_row   = r_omem[r_orp].row;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (r4_v) begin
                r_owp <= r_owp + OW'(1);
            end
            if (opop) begin
                r_orp <= r_orp + OW'(1);
            end
            r_ocnt <= r_ocnt + (OW+1)'(r4_v) - (OW+1)'(opop);
        end
    end
    always_ff @(posedge i_clk) begin
        if (r4_v) begin
            r_omem[r_owp] <= '{vote: r4_vote[VoteWidth-1:0], col: r4_col, row: r4_row};
        end
    end
endmodule

FILE: rtl/harris_corner_vote_window.sv
// harris corner vote window over a raster stream of sobel gradient pairs
// usage:
//   input queue side: push with full; one gradient pair per item in raster
//   order, one item per cycle while full stays low
//   result queue side: empty with pop; a vote and its window centre
//   coordinates for centres in columns 2..width-3 and rows 2..height-2
//   configuration: cfg valid/ready write of image width (index 0) and image
//   height (index 1), taken in any cycle; user writes only while idle, unenforced
//   throughput one item per cycle while full stays low; each line store has
//   a read port and a write port and is read and written once per item
//   once the pixel after the centre is taken, its vote goes through the front
//   stage, mid queue, back stages and result queue, then shows with empty low
//   reset clears counters, window and queues; line stores are not cleared
//   when the receiver stalls, votes collect in an eight entry result queue,
//   then the mid queue fills and full rises
// depends on hcv_pkg, hcv_ram, hcv_front, hcv_fifo, hcv_back
module harris_corner_vote_window #(
    parameter int unsigned MAX_WIDTH = 2048,
    parameter int unsigned MAX_HEIGHT = 2048
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [7:0]                   i_grad_x,
    input  logic signed [7:0]                   i_grad_y,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [hcv_pkg::VoteWidth-1:0] o_vote,
    output logic [hcv_pkg::CoordWidth-1:0]      o_center_col,
    output logic [hcv_pkg::CoordWidth-1:0]      o_center_row,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [hcv_pkg::CfgWidth-1:0]        i_cfg_data
);
    import hcv_pkg::*;

    logic [CfgWidth-1:0] r_width, r_height;
    logic q_full, q_push, q_empty, q_pop;
    t_pix q_in, q_out;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CfgWidth'(640);
            r_height <= CfgWidth'(480);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default:    r_width  <= r_width;
            endcase
        end
    end

    hcv_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_grad_x (i_grad_x),
        .i_grad_y (i_grad_y),
        .i_width  (r_width),
        .i_height (r_height),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_in)
    );

    hcv_fifo #(.DEPTH(4)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    hcv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_q_data  (q_out),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_vote    (o_vote),
        .o_col     (o_center_col),
        .o_row     (o_center_row)
    );
endmodule

FILE: tb/harris_corner_vote_window_tb.sv
// self-checking bench for the harris corner vote window: random gradient frames in,
// predicted votes compared field by field; depends on hcv_pkg and harris_corner_vote_window
module harris_corner_vote_window_tb;
    import hcv_pkg::*;

    localparam int MaxW = 2048;
    localparam int MaxH = 2048;
    localparam int CycleLimit = 2000000;

    typedef struct packed {
        logic signed [7:0] gx;
        logic signed [7:0] gy;
    } t_grad;

    typedef struct packed {
        logic signed [VoteWidth-1:0] vote;
        logic [CoordWidth-1:0]       col;
        logic [CoordWidth-1:0]       row;
        logic                        known;
    } t_vote;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         push;
    logic                         full;
    logic signed [7:0]            i_grad_x;
    logic signed [7:0]            i_grad_y;
    logic                         empty;
    logic                         pop;
    logic signed [VoteWidth-1:0]  o_vote;
    logic [CoordWidth-1:0]        o_center_col;
    logic [CoordWidth-1:0]        o_center_row;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic                         i_cfg_index;
    logic [CfgWidth-1:0]          i_cfg_data;

    harris_corner_vote_window dut (.*);

    // predictor state; ok flags mark line store words that hold written data
    logic [15:0] row_prev [MaxW];
    logic [15:0] row_prev2 [MaxW];
    bit          row_prev_ok [MaxW];
    bit          row_prev2_ok [MaxW];
    logic [15:0] win [9] = '{default: 16'h0};
    bit          win_ok [9] = '{default: 1'b1};
    int unsigned pix_col = 0;
    int unsigned pix_row = 0;
    int unsigned img_w, img_h;

    t_grad pending_grads[$];
    t_vote expected_votes[$];
    int    errors;
    int    cycles;
    bit    sender_hold;     // sender pause requested by the sequencer
    bit    rx_long_stall;   // long receiver hold-off requested
    int    rx_stall_cnt;

    task automatic report(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    function automatic longint sx8(input logic [7:0] v);
        return longint'($signed(v));
    endfunction

    // advance the raster model by one pixel, queueing any vote it yields
    task automatic predict_pixel(input t_grad g);
        int unsigned w, h, c, r;
        logic [15:0] cur, up1, up2;
        bit ok1, ok2, known;
        longint ixx, iyy, ixy, qxy, det, tr, v;
        t_vote e;
        w = (img_w < MaxW) ? img_w : MaxW;
        h = (img_h < MaxH) ? img_h : MaxH;
        c = pix_col;
        r = pix_row;
        cur = {g.gy, g.gx};
        up1 = '0;
        up2 = '0;
        ok1 = 1'b1;
        ok2 = 1'b1;
        if (c < MaxW) begin
            up1 = row_prev[c];
            up2 = row_prev2[c];
            ok1 = row_prev_ok[c];
            ok2 = row_prev2_ok[c];
            row_prev2[c] = up1;
            row_prev2_ok[c] = ok1;
            row_prev[c] = cur;
            row_prev_ok[c] = 1'b1;
        end
        for (int k = 0; k < 3; k++) begin
            win[k*3] = win[k*3+1];
            win[k*3+1] = win[k*3+2];
            win_ok[k*3] = win_ok[k*3+1];
            win_ok[k*3+1] = win_ok[k*3+2];
        end
        win[2] = up2;
        win[5] = up1;
        win[8] = cur;
        win_ok[2] = ok2;
        win_ok[5] = ok1;
        win_ok[8] = 1'b1;
        if (c >= 3 && c + 2 <= w && r >= 3 && r + 1 <= h) begin
            ixx = 0; iyy = 0; ixy = 0;
            known = 1'b1;
            for (int k = 0; k < 9; k++) begin
                ixx += sx8(win[k][7:0]) * sx8(win[k][7:0]);
                iyy += sx8(win[k][15:8]) * sx8(win[k][15:8]);
                ixy += sx8(win[k][7:0]) * sx8(win[k][15:8]);
                known = known && win_ok[k];
            end
            qxy = ixy / 8;
            det = (ixx / 8) * (iyy / 8) - qxy * qxy;
            tr = (ixx + iyy) / 8;
            v = det - (tr * tr * 3) / 64;
            e.vote = v[VoteWidth-1:0];
            e.col = CoordWidth'(c - 1);
            e.row = CoordWidth'(r - 1);
            e.known = known;
            expected_votes.push_back(e);
        end
        if (c + 1 >= w) begin
            pix_col = 0;
            pix_row = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            pix_col = c + 1;
        end
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // input driver: bursts and gaps
    int burst_left, gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            i_grad_x <= '0;
            i_grad_y <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            automatic bit acc = push && !full;
            automatic bit offer;
            automatic int nb = burst_left, ng = gap_left;
            if (acc) begin
                predict_pixel(pending_grads.pop_front());
            end
            if (ng > 0) begin
                ng--;
                offer = 1'b0;
            end else if (nb == 0) begin
                if ($urandom_range(3) == 0) nb = $urandom_range(200, 20);
                else nb = $urandom_range(12, 1);
                ng = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
                offer = 1'b1;
            end else begin
                offer = 1'b1;
            end
            offer = offer && !sender_hold && pending_grads.size() > 0;
            if (offer) begin
                nb--;
                if (nb == 0) ng = gap_left == 0 ? $urandom_range(5) : ng;
                i_grad_x <= pending_grads[0].gx;
                i_grad_y <= pending_grads[0].gy;
            end
            push <= offer;
            burst_left <= nb;
            gap_left <= ng;
        end
    end

    // result monitor and receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            rx_stall_cnt <= 0;
        end else begin
            if (pop && !empty) begin
                if (expected_votes.size() == 0) begin
                    report($sformatf("unexpected vote %0d at (%0d,%0d)",
                                     o_vote, o_center_col, o_center_row));
                end else begin
                    automatic t_vote e = expected_votes.pop_front();
                    if (e.known && o_vote !== e.vote)
                        report($sformatf("vote %0d want %0d at (%0d,%0d)",
                                         o_vote, e.vote, e.col, e.row));
                    if (o_center_col !== e.col)
                        report($sformatf("center_col %0d want %0d", o_center_col, e.col));
                    if (o_center_row !== e.row)
                        report($sformatf("center_row %0d want %0d", o_center_row, e.row));
                end
            end
            if (rx_long_stall && rx_stall_cnt == 0) begin
                rx_stall_cnt <= 400;
                pop <= 1'b0;
            end else if (rx_stall_cnt > 1) begin
                rx_stall_cnt <= rx_stall_cnt - 1;
                pop <= 1'b0;
            end else begin
                rx_stall_cnt <= (rx_stall_cnt == 1 && !rx_long_stall) ? 0 : rx_stall_cnt;
                pop <= (cycles % 64 < 24) ? 1'b1 : ($urandom_range(3) != 0);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic cfg_write(input logic idx, input int unsigned val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CfgWidth'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_WIDTH) img_w = val & 12'hFFF;
        else img_h = val & 12'hFFF;
    endtask

    task automatic drain();
        while (pending_grads.size() != 0) @(posedge i_clk);
        while (expected_votes.size() != 0 || push) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_grad rand_grad(input int mode);
        t_grad g;
        case (mode)
            0: g = '{gx: 8'sh80, gy: 8'sh80};
            1: g = '{gx: 8'sh7f, gy: 8'sh80};
            2: g = '{gx: 8'sh80, gy: 8'sh7f};
            default: g = '{gx: 8'($urandom), gy: 8'($urandom)};
        endcase
        return g;
    endfunction

    // queue a number of pixels; first frame covers whole rows so store reads stay written
    task automatic queue_pixels(input int n, input int mode);
        for (int i = 0; i < n; i++)
            pending_grads.push_back(rand_grad(mode == 4 ? $urandom_range(4) : mode));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_WIDTH;
        i_cfg_data = '0;
        sender_hold = 1'b0;
        rx_long_stall = 1'b0;
        img_w = 640; img_h = 480;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: small geometry, extreme gradients, a full frame and half a row
        cfg_write(CFG_WIDTH, 10);
        cfg_write(CFG_HEIGHT, 5);
        queue_pixels(10, 0);
        queue_pixels(10, 1);
        queue_pixels(10, 2);
        queue_pixels(25, 4);
        drain();

        // long receiver hold-off with the sender still offering
        rx_long_stall = 1'b1;
        queue_pixels(120, 4);
        repeat (300) @(posedge i_clk);
        rx_long_stall = 1'b0;
        drain();

        // sender pause mid-stream until every vote has come
        queue_pixels(40, 4);
        repeat (15) @(posedge i_clk);
        sender_hold = 1'b1;
        while (expected_votes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        sender_hold = 1'b0;
        drain();

        // mid-frame geometry changes
        cfg_write(CFG_WIDTH, 13);
        cfg_write(CFG_HEIGHT, 7);
        queue_pixels(100, 4);
        drain();

        // tiny and zero geometry: no votes, counters still wrap
        cfg_write(CFG_WIDTH, 0);
        cfg_write(CFG_HEIGHT, 1);
        queue_pixels(20, 4);
        drain();
        cfg_write(CFG_WIDTH, 16);
        cfg_write(CFG_HEIGHT, 0);
        queue_pixels(40, 4);
        drain();

        // largest and oversized widths with an oversized height
        cfg_write(CFG_HEIGHT, 4095);
        cfg_write(CFG_WIDTH, 2048);
        queue_pixels(150, 3);
        drain();
        cfg_write(CFG_WIDTH, 4095);
        queue_pixels(60, 3);
        drain();

        // random geometries, mostly small
        for (int ph = 0; ph < 8; ph++) begin
            cfg_write(CFG_WIDTH, $urandom_range(24, 10));
            cfg_write(CFG_HEIGHT, (ph == 7) ? 2048 : $urandom_range(12, 5));
            queue_pixels(40, 4);
            drain();
        end

        repeat (30) @(posedge i_clk);
        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

endmodule
